FILE: hw/rtl/j2g_pkg.sv
// ----------------------------------------------------------------------------
// j2g_pkg
// Shared widths, register indexes and pipeline types of the J2 gravity unit.
// ----------------------------------------------------------------------------
package j2g_pkg;

  localparam int POS_WIDTH     = 48;
  localparam int ACC_FRAC_BITS = 32;
  localparam int ACC_WIDTH     = 48;

  localparam int MU_W      = 53;
  localparam int RAD_W     = 40;
  localparam int J2_W      = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 53;

  localparam logic [CFG_IDX_W-1:0] REG_GRAV_PARAM  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BODY_RADIUS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_J2_COEFF    = 2'd2;

  localparam logic [MU_W-1:0]  GRAV_RESET   = 53'd398600441800000;
  localparam logic [RAD_W-1:0] RADIUS_RESET = 40'd637813700;
  localparam logic [J2_W-1:0]  J2_RESET     = 32'd1190364274;

  localparam int SQ_W   = 2 * POS_WIDTH;
  localparam int S_W    = SQ_W + 2;
  localparam int CMP_W  = SQ_W + 130;
  localparam int ZR_W   = SQ_W + 32;
  localparam int MUK_W  = MU_W + 14;
  localparam int NA_W   = MUK_W + ACC_FRAC_BITS;
  localparam int NF_W   = 2 * RAD_W + J2_W + 2;
  localparam int UR_W   = SQ_W + 124;
  localparam int UQ_W   = S_W + 63;
  localparam int A_Q    = 64;
  localparam int F_Q    = 59;
  localparam int Z_Q    = 33;
  localparam int U_Q    = 63;
  localparam int F_SHIFT = 9;
  localparam int ITER_STEPS = A_Q;

  localparam int TDATA_IN_W  = ((3 * POS_WIDTH + 7) / 8) * 8;
  localparam int TDATA_OUT_W = ((3 * ACC_WIDTH + 7) / 8) * 8;
  localparam int TUSER_OUT_W = 2;

  localparam logic [S_W-1:0] DEGEN_LIMIT = S_W'(10000);
  localparam logic [F_Q-1:0] F_CAP = F_Q'(1) << (F_Q - 1);

  typedef struct packed {
    logic [S_W-1:0]             s;
    logic [2:0]                 neg;
    logic                       degen;
    logic [NA_W-1:0]            a_rem;
    logic [A_Q-1:0]             a_q;
    logic                       a_over;
    logic [NF_W-1:0]            f_rem;
    logic [F_Q-1:0]             f_q;
    logic                       f_over;
    logic [ZR_W-1:0]            z_rem;
    logic [Z_Q-1:0]             z_q;
    logic [2:0][UR_W-1:0]       u_rem;
    logic [2:0][UQ_W-1:0]       u_acc;
    logic [2:0][U_Q-1:0]        u;
  } iter_t;

  typedef struct packed {
    logic [2:0][ACC_WIDTH-1:0]  accel;
    logic                       sat;
    logic                       degen;
  } result_t;

endpackage

FILE: hw/rtl/j2g_cfg.sv
// ----------------------------------------------------------------------------
// j2g_cfg
// Configuration registers and the derived division numerators.
// ----------------------------------------------------------------------------
module j2g_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [j2g_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [j2g_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic [j2g_pkg::NA_W-1:0]           na,
  output logic [j2g_pkg::NF_W-1:0]           nf
);
  import j2g_pkg::*;

  localparam int RH = RAD_W / 2;
  localparam int RL = RAD_W - RH;
  localparam int RE2_W = 2 * RAD_W;
  localparam int J3_W = J2_W + 2;
  localparam int C0 = 27;
  localparam int C1 = 54;

  logic [MU_W-1:0]  grav_parameter;
  logic [RAD_W-1:0] body_radius;
  logic [J2_W-1:0]  j2_coeff;

  logic [MUK_W-1:0] mu_k;
  logic [RE2_W-1:0] r_hh, r_hl, r_ll;
  logic [J3_W-1:0]  j3_a, j3_b;
  logic [RE2_W-1:0] re2;
  logic [NF_W-1:0]  p0, p1, p2;
  logic [NF_W-1:0]  nf_sum;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grav_parameter <= GRAV_RESET;
      body_radius    <= RADIUS_RESET;
      j2_coeff       <= J2_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GRAV_PARAM:  grav_parameter <= cfg_data[MU_W-1:0];
        REG_BODY_RADIUS: body_radius    <= cfg_data[RAD_W-1:0];
        REG_J2_COEFF:    j2_coeff       <= cfg_data[J2_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    mu_k <= MUK_W'(grav_parameter) * MUK_W'(14'd10000);
    r_hh <= RE2_W'(body_radius[RAD_W-1:RL]) * RE2_W'(body_radius[RAD_W-1:RL]);
    r_hl <= RE2_W'(body_radius[RAD_W-1:RL]) * RE2_W'(body_radius[RL-1:0]);
    r_ll <= RE2_W'(body_radius[RL-1:0]) * RE2_W'(body_radius[RL-1:0]);
    j3_a <= J3_W'(j2_coeff) + (J3_W'(j2_coeff) << 1);
    re2  <= (r_hh << (2 * RL)) + (r_hl << (RL + 1)) + r_ll;
    j3_b <= j3_a;
    p0   <= NF_W'(re2[C0-1:0]) * NF_W'(j3_b);
    p1   <= NF_W'(re2[C1-1:C0]) * NF_W'(j3_b);
    p2   <= NF_W'(re2[RE2_W-1:C1]) * NF_W'(j3_b);
    nf_sum <= p0 + (p1 << C0) + (p2 << C1);
  end

  assign na = {mu_k, {ACC_FRAC_BITS{1'b0}}};
  assign nf = nf_sum;

endmodule

FILE: hw/rtl/j2g_front.sv
// ----------------------------------------------------------------------------
// j2g_front
// Magnitudes, squares, r squared, the degenerate flag and the start values of the shared
// divide and root steps.
// ----------------------------------------------------------------------------
module j2g_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic [2:0][j2g_pkg::POS_WIDTH-1:0] pos,
  input  logic [j2g_pkg::NA_W-1:0]           na,
  input  logic [j2g_pkg::NF_W-1:0]           nf,
  output logic                               out_valid,
  output j2g_pkg::iter_t                     out_item
);
  import j2g_pkg::*;

  localparam int HL = (POS_WIDTH + 1) / 2;

  typedef struct packed {
    logic [2:0][POS_WIDTH-1:0] mag;
    logic [2:0]                neg;
  } f1_t;

  typedef struct packed {
    logic [2:0][SQ_W-1:0] hh;
    logic [2:0][SQ_W-1:0] hl;
    logic [2:0][SQ_W-1:0] ll;
    logic [2:0]           neg;
  } f2_t;

  typedef struct packed {
    logic [2:0][SQ_W-1:0] sq;
    logic [2:0]           neg;
  } f3_t;

  typedef struct packed {
    logic [2:0][SQ_W-1:0] sq;
    logic [S_W-1:0]       s;
    logic [2:0]           neg;
    logic                 degen;
  } f4_t;

  f1_t   st1, st1_next;
  f2_t   st2, st2_next;
  f3_t   st3, st3_next;
  f4_t   st4, st4_next;
  iter_t st5_next;
  logic  v1, v2, v3, v4;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      st1_next.neg[i] = pos[i][POS_WIDTH-1];
      st1_next.mag[i] = pos[i][POS_WIDTH-1] ? (~pos[i] + POS_WIDTH'(1)) : pos[i];
    end
  end

  always_comb begin
    st2_next.neg = st1.neg;
    for (int i = 0; i < 3; i++) begin
      st2_next.hh[i] = SQ_W'(st1.mag[i][POS_WIDTH-1:HL]) * SQ_W'(st1.mag[i][POS_WIDTH-1:HL]);
      st2_next.hl[i] = SQ_W'(st1.mag[i][POS_WIDTH-1:HL]) * SQ_W'(st1.mag[i][HL-1:0]);
      st2_next.ll[i] = SQ_W'(st1.mag[i][HL-1:0]) * SQ_W'(st1.mag[i][HL-1:0]);
    end
  end

  always_comb begin
    st3_next.neg = st2.neg;
    for (int i = 0; i < 3; i++) begin
      st3_next.sq[i] = (st2.hh[i] << (2 * HL)) + (st2.hl[i] << (HL + 1)) + st2.ll[i];
    end
  end

  always_comb begin
    st4_next.sq    = st3.sq;
    st4_next.neg   = st3.neg;
    st4_next.s     = S_W'(st3.sq[0]) + S_W'(st3.sq[1]) + S_W'(st3.sq[2]);
    st4_next.degen = st4_next.s < DEGEN_LIMIT;
  end

  always_comb begin
    st5_next.s      = st4.s;
    st5_next.neg    = st4.neg;
    st5_next.degen  = st4.degen;
    st5_next.a_rem  = na;
    st5_next.a_q    = '0;
    st5_next.a_over = CMP_W'(na >> A_Q) >= CMP_W'(st4.s);
    st5_next.f_rem  = nf;
    st5_next.f_q    = '0;
    st5_next.f_over = CMP_W'(nf >> (F_Q + F_SHIFT)) >= CMP_W'(st4.s);
    st5_next.z_rem  = ZR_W'(st4.sq[2]) << 32;
    st5_next.z_q    = '0;
    for (int i = 0; i < 3; i++) begin
      st5_next.u_rem[i] = UR_W'(st4.sq[i]) << 124;
      st5_next.u_acc[i] = '0;
      st5_next.u[i]     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st1 <= st1_next;
      st2 <= st2_next;
      st3 <= st3_next;
      st4 <= st4_next;
      out_item <= st5_next;
    end
  end

endmodule

FILE: hw/rtl/j2g_iter_stage.sv
// ----------------------------------------------------------------------------
// j2g_iter_stage
// One bit of each long division and 3 unit-vector root searches still running.
// ----------------------------------------------------------------------------
module j2g_iter_stage #(
  parameter int STEP = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  j2g_pkg::iter_t in_item,
  output logic           out_valid,
  output j2g_pkg::iter_t out_item
);
  import j2g_pkg::*;

  localparam int ABIT = A_Q - 1 - STEP;

  iter_t item_next;
  logic [NA_W-1:0] a_rem_next;
  logic [A_Q-1:0]  a_q_next;
  logic [NF_W-1:0] f_rem_next;
  logic [F_Q-1:0]  f_q_next;
  logic [ZR_W-1:0] z_rem_next;
  logic [Z_Q-1:0]  z_q_next;
  logic [2:0][UR_W-1:0] u_rem_next;
  logic [2:0][UQ_W-1:0] u_acc_next;
  logic [2:0][U_Q-1:0]  u_next;

  always_comb begin
    a_rem_next = in_item.a_rem;
    a_q_next   = in_item.a_q;
    if (CMP_W'(in_item.a_rem >> ABIT) >= CMP_W'(in_item.s)) begin
      a_rem_next     = in_item.a_rem - NA_W'(CMP_W'(in_item.s) << ABIT);
      a_q_next[ABIT] = 1'b1;
    end
  end

  if (STEP < F_Q) begin : g_f
    localparam int FBIT = F_Q - 1 - STEP;
    always_comb begin
      f_rem_next = in_item.f_rem;
      f_q_next   = in_item.f_q;
      if (CMP_W'(in_item.f_rem >> (FBIT + F_SHIFT)) >= CMP_W'(in_item.s)) begin
        f_rem_next     = in_item.f_rem - NF_W'(CMP_W'(in_item.s) << (FBIT + F_SHIFT));
        f_q_next[FBIT] = 1'b1;
      end
    end
  end else begin : g_f_hold
    assign f_rem_next = in_item.f_rem;
    assign f_q_next   = in_item.f_q;
  end

  if (STEP < Z_Q) begin : g_z
    localparam int ZBIT = Z_Q - 1 - STEP;
    always_comb begin
      z_rem_next = in_item.z_rem;
      z_q_next   = in_item.z_q;
      if (CMP_W'(in_item.z_rem >> ZBIT) >= CMP_W'(in_item.s)) begin
        z_rem_next     = in_item.z_rem - ZR_W'(CMP_W'(in_item.s) << ZBIT);
        z_q_next[ZBIT] = 1'b1;
      end
    end
  end else begin : g_z_hold
    assign z_rem_next = in_item.z_rem;
    assign z_q_next   = in_item.z_q;
  end

  if (STEP < U_Q) begin : g_u
    localparam int UBIT = U_Q - 1 - STEP;
    logic [2:0][CMP_W-1:0] trial;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        trial[i] = (CMP_W'(in_item.u_acc[i]) << (UBIT + 1))
                 + (CMP_W'(in_item.s) << (2 * UBIT));
        u_rem_next[i] = in_item.u_rem[i];
        u_acc_next[i] = in_item.u_acc[i];
        u_next[i]     = in_item.u[i];
        if (CMP_W'(in_item.u_rem[i]) >= trial[i]) begin
          u_rem_next[i]   = in_item.u_rem[i] - UR_W'(trial[i]);
          u_acc_next[i]   = in_item.u_acc[i] + (UQ_W'(in_item.s) << UBIT);
          u_next[i][UBIT] = 1'b1;
        end
      end
    end
  end else begin : g_u_hold
    assign u_rem_next = in_item.u_rem;
    assign u_acc_next = in_item.u_acc;
    assign u_next     = in_item.u;
  end

  always_comb begin
    item_next       = in_item;
    item_next.a_rem = a_rem_next;
    item_next.a_q   = a_q_next;
    item_next.f_rem = f_rem_next;
    item_next.f_q   = f_q_next;
    item_next.z_rem = z_rem_next;
    item_next.z_q   = z_q_next;
    item_next.u_rem = u_rem_next;
    item_next.u_acc = u_acc_next;
    item_next.u     = u_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= item_next;
    end
  end

endmodule

FILE: hw/rtl/j2g_back.sv
// ----------------------------------------------------------------------------
// j2g_back
// Oblateness factor, component products, sign and saturation.
// ----------------------------------------------------------------------------
module j2g_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  j2g_pkg::iter_t   in_item,
  output logic             out_valid,
  output j2g_pkg::result_t out_item
);
  import j2g_pkg::*;

  localparam int W_W  = 36;
  localparam int WM_W = 35;
  localparam int T_W  = 62;
  localparam int FM_W = 61;
  localparam int M_W  = 93;

  typedef struct packed {
    logic [A_Q-1:0]       a;
    logic [F_Q-1:0]       f;
    logic [1:0][WM_W-1:0] wmag;
    logic [1:0]           wneg;
    logic [2:0][U_Q-1:0]  u;
    logic [2:0]           neg;
    logic                 degen;
  } b1_t;

  typedef struct packed {
    logic [2:0][3:0][63:0] au;
    logic [1:0][66:0]      fw_lo;
    logic [1:0][61:0]      fw_hi;
    logic [1:0]            wneg;
    logic [2:0]            neg;
    logic                  degen;
  } b2_t;

  typedef struct packed {
    logic [2:0][63:0]    m1;
    logic [1:0][T_W-1:0] t;
    logic [1:0]          wneg;
    logic [2:0]          neg;
    logic                degen;
  } b3_t;

  typedef struct packed {
    logic [2:0][63:0]     m1;
    logic [1:0][FM_W-1:0] fmag;
    logic [1:0]           fneg;
    logic [2:0]           neg;
    logic                 degen;
  } b4_t;

  typedef struct packed {
    logic [2:0][3:0][63:0] mf;
    logic [1:0]            fneg;
    logic [2:0]            neg;
    logic                  degen;
  } b5_t;

  b1_t st1, st1_next;
  b2_t st2, st2_next;
  b3_t st3, st3_next;
  b4_t st4, st4_next;
  b5_t st5, st5_next;
  result_t st6_next;
  logic v1, v2, v3, v4, v5;

  logic [W_W-1:0] five;
  logic [1:0][W_W-1:0] w;

  always_comb begin
    st1_next.a = in_item.a_over ? '1 : in_item.a_q;
    st1_next.f = (in_item.f_over || in_item.f_q > F_CAP) ? F_CAP : in_item.f_q;
    five = W_W'(in_item.z_q) + (W_W'(in_item.z_q) << 2);
    w[0] = five - (W_W'(1) << 32);
    w[1] = five - (W_W'(3) << 32);
    for (int j = 0; j < 2; j++) begin
      st1_next.wneg[j] = w[j][W_W-1];
      st1_next.wmag[j] = w[j][W_W-1] ? WM_W'(~w[j] + W_W'(1)) : WM_W'(w[j]);
    end
    st1_next.u     = in_item.u;
    st1_next.neg   = in_item.neg;
    st1_next.degen = in_item.degen;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      st2_next.au[i][0] = 64'(st1.a[31:0]) * 64'(st1.u[i][31:0]);
      st2_next.au[i][1] = 64'(st1.a[31:0]) * 64'(st1.u[i][U_Q-1:32]);
      st2_next.au[i][2] = 64'(st1.a[63:32]) * 64'(st1.u[i][31:0]);
      st2_next.au[i][3] = 64'(st1.a[63:32]) * 64'(st1.u[i][U_Q-1:32]);
    end
    for (int j = 0; j < 2; j++) begin
      st2_next.fw_lo[j] = 67'(st1.f[31:0]) * 67'(st1.wmag[j]);
      st2_next.fw_hi[j] = 62'(st1.f[F_Q-1:32]) * 62'(st1.wmag[j]);
    end
    st2_next.wneg  = st1.wneg;
    st2_next.neg   = st1.neg;
    st2_next.degen = st1.degen;
  end

  logic [2:0][127:0] au_sum;
  logic [1:0][93:0]  fw_sum;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      au_sum[i] = (128'(st2.au[i][3]) << 64) + (128'(st2.au[i][1]) << 32)
                + (128'(st2.au[i][2]) << 32) + 128'(st2.au[i][0]);
      st3_next.m1[i] = au_sum[i][125:62];
    end
    for (int j = 0; j < 2; j++) begin
      fw_sum[j] = (94'(st2.fw_hi[j]) << 32) + 94'(st2.fw_lo[j]);
      st3_next.t[j] = fw_sum[j][93:32];
    end
    st3_next.wneg  = st2.wneg;
    st3_next.neg   = st2.neg;
    st3_next.degen = st2.degen;
  end

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      if (st3.wneg[j]) begin
        st4_next.fmag[j] = FM_W'(st3.t[j]) + (FM_W'(1) << 32);
        st4_next.fneg[j] = 1'b0;
      end else if (st3.t[j] > (T_W'(1) << 32)) begin
        st4_next.fmag[j] = FM_W'(st3.t[j]) - (FM_W'(1) << 32);
        st4_next.fneg[j] = 1'b1;
      end else begin
        st4_next.fmag[j] = (FM_W'(1) << 32) - FM_W'(st3.t[j]);
        st4_next.fneg[j] = 1'b0;
      end
    end
    st4_next.m1    = st3.m1;
    st4_next.neg   = st3.neg;
    st4_next.degen = st3.degen;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      st5_next.mf[i][0] = 64'(st4.m1[i][31:0]) * 64'(st4.fmag[i / 2][31:0]);
      st5_next.mf[i][1] = 64'(st4.m1[i][31:0]) * 64'(st4.fmag[i / 2][FM_W-1:32]);
      st5_next.mf[i][2] = 64'(st4.m1[i][63:32]) * 64'(st4.fmag[i / 2][31:0]);
      st5_next.mf[i][3] = 64'(st4.m1[i][63:32]) * 64'(st4.fmag[i / 2][FM_W-1:32]);
    end
    st5_next.fneg  = st4.fneg;
    st5_next.neg   = st4.neg;
    st5_next.degen = st4.degen;
  end

  logic [2:0][127:0]       mf_sum;
  logic [2:0][M_W-1:0]     m;
  logic [2:0][M_W-1:0]     lim;
  logic [2:0]              out_neg;
  logic [2:0]              clip;
  logic [2:0][ACC_WIDTH-1:0] mag;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mf_sum[i] = (128'(st5.mf[i][3]) << 64) + (128'(st5.mf[i][1]) << 32)
                + (128'(st5.mf[i][2]) << 32) + 128'(st5.mf[i][0]);
      m[i] = mf_sum[i][124:32];
      out_neg[i] = st5.neg[i] == st5.fneg[i / 2];
      lim[i] = out_neg[i] ? (M_W'(1) << (ACC_WIDTH - 1))
                          : (M_W'(1) << (ACC_WIDTH - 1)) - M_W'(1);
      clip[i] = m[i] > lim[i];
      mag[i] = clip[i] ? ACC_WIDTH'(lim[i]) : m[i][ACC_WIDTH-1:0];
      st6_next.accel[i] = st5.degen ? '0 : (out_neg[i] ? (~mag[i] + ACC_WIDTH'(1)) : mag[i]);
    end
    st6_next.sat   = !st5.degen && (clip != 3'b000);
    st6_next.degen = st5.degen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st1 <= st1_next;
      st2 <= st2_next;
      st3 <= st3_next;
      st4 <= st4_next;
      st5 <= st5_next;
      out_item <= st6_next;
    end
  end

endmodule

FILE: hw/rtl/j2_gravity_acceleration_unit.sv
// ----------------------------------------------------------------------------
// j2_gravity_acceleration_unit
// Point-mass plus J2 gravity acceleration for a stream of positions.
// ----------------------------------------------------------------------------
// Input stream s_*: one position per transaction, x, y, z in signed cm.
// Output stream m_*: one acceleration per position, same order, in units of
// 2^-32 m/s^2; m_tuser flags a degenerate distance or a clipped component.
// Configuration port cfg_*: index 0 mu, 1 equatorial radius, 2 J2 * 2^40;
// write only while no transaction is in flight.
// Throughput: one transaction per cycle while s_tready is high; the 64-step divide and root chain
// sets the depth, every step a register stage.
// Reset loads the default constants and empties the pipeline.
// On a stalled m_tready the result holds, a skid register takes one more
// result, and then s_tready drops until the skid register moves into the
// output register.
// ----------------------------------------------------------------------------
module j2_gravity_acceleration_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [j2g_pkg::TDATA_IN_W-1:0]      s_tdata,   // position_x, position_y, position_z
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [j2g_pkg::TDATA_OUT_W-1:0]     m_tdata,   // accel_x, accel_y, accel_z
  output logic [j2g_pkg::TUSER_OUT_W-1:0]     m_tuser,   // degenerate, saturated
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [j2g_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [j2g_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import j2g_pkg::*;

  logic en;
  logic [NA_W-1:0] na;
  logic [NF_W-1:0] nf;
  logic [2:0][POS_WIDTH-1:0] pos;

  iter_t chain [ITER_STEPS+1];
  logic [ITER_STEPS:0] chain_valid;

  logic    back_valid;
  result_t back_item;
  result_t out_item, skid_item;
  logic    out_valid, skid_valid;
  logic    take;

  assign en = !skid_valid;
  assign s_tready = en;
  assign take = out_valid && m_tready;

  assign pos[0] = s_tdata[POS_WIDTH-1:0];
  assign pos[1] = s_tdata[2*POS_WIDTH-1:POS_WIDTH];
  assign pos[2] = s_tdata[3*POS_WIDTH-1:2*POS_WIDTH];

  j2g_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .na        (na),
    .nf        (nf)
  );

  j2g_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .pos       (pos),
    .na        (na),
    .nf        (nf),
    .out_valid (chain_valid[0]),
    .out_item  (chain[0])
  );

  for (genvar k = 0; k < ITER_STEPS; k++) begin : g_iter
    j2g_iter_stage #(.STEP(k)) u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (chain_valid[k]),
      .in_item   (chain[k]),
      .out_valid (chain_valid[k+1]),
      .out_item  (chain[k+1])
    );
  end

  j2g_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (chain_valid[ITER_STEPS]),
    .in_item   (chain[ITER_STEPS]),
    .out_valid (back_valid),
    .out_item  (back_item)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (back_valid) begin
      if (!out_valid || take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        out_item <= skid_item;
      end
    end else if (back_valid) begin
      if (!out_valid || take) begin
        out_item <= back_item;
      end else begin
        skid_item <= back_item;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = TDATA_OUT_W'({out_item.accel[2], out_item.accel[1], out_item.accel[0]});
  assign m_tuser  = {out_item.sat, out_item.degen};

  assert property (@(posedge clk) disable iff (rst) skid_valid |-> out_valid)
    else $error("skid register holds a result while the output is empty");

  assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !m_tready))
    else $error("skid register filled without an output stall");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.degen) |-> (m_tdata == '0 && !out_item.sat))
    else $error("degenerate result carries a nonzero acceleration");

endmodule
